FILE: src/ird_pkg.sv
// Package for the integer to radix digits unit: widths, register indexes,
// the control state type and the digit table byte lookup.
// Depends on nothing; every other file uses it by scoped names.
package ird_pkg;

  // Field widths and sizing.
  localparam int VALUE_BITS  = 32;
  localparam int MAX_RADIX   = 16;
  localparam int TABLE_BYTES = 16;
  localparam int CHAR_W      = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 1;
  localparam int TABLE_POS_W = $clog2(TABLE_BYTES);
  localparam int RADIX_W     = $clog2(MAX_RADIX + 1);
  localparam int DIGIT_W     = $clog2(MAX_RADIX);
  localparam int REM_W       = DIGIT_W + 1;
  localparam int MAX_DIGITS  = VALUE_BITS;
  localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int BIT_W       = $clog2(VALUE_BITS);

  // Characters that may not appear in a digit table.
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_CHARS_LOW  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_CHARS_HIGH = 1'b1;

  // Control states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_OUT
  } state_t;

  // Radix found in the table and whether the table forms a usable base.
  typedef struct packed {
    logic               valid;
    logic [RADIX_W-1:0] radix;
  } base_info_t;

  // Per-cycle status of the serial divider.
  typedef struct packed {
    logic push;
    logic done;
  } div_status_t;

  // Byte pos of the sixteen-byte digit table held in two registers.
  function automatic logic [CHAR_W-1:0] table_byte(
    input logic [CFG_DATA_W-1:0]  lo,
    input logic [CFG_DATA_W-1:0]  hi,
    input logic [TABLE_POS_W-1:0] pos
  );
    logic [2*CFG_DATA_W-1:0] tbl;
    tbl = {hi, lo};
    return tbl[pos*CHAR_W +: CHAR_W];
  endfunction

endpackage

FILE: src/integer_to_radix_digits_unit.sv
// Integer to radix digits unit. An item is converted by bit-serial division
// (one quotient bit a cycle in the serial divider), then its digits leave one
// a cycle while out_ready is high, most significant first. The next item is
// taken once the last digit is delivered. An invalid digit table drops the
// item in its accept cycle. Synchronous reset clears the table to zero (no
// valid base), empties the store, idles.
module integer_to_radix_digits_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ird_pkg::VALUE_BITS-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ird_pkg::CHAR_W-1:0]          out_digit_char,
  output logic                                out_last_digit,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ird_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ird_pkg::CFG_DATA_W-1:0]      cfg_data
);

  ird_pkg::state_t                state_r, state_nxt;
  logic [ird_pkg::CFG_DATA_W-1:0] chars_low_r, chars_high_r;
  ird_pkg::base_info_t            base;
  ird_pkg::div_status_t           div_status;
  logic [ird_pkg::DIGIT_W-1:0]    div_digit;
  logic [ird_pkg::DIGIT_W-1:0]    top_digit;
  logic [ird_pkg::COUNT_W-1:0]    count;
  logic                           last_slot;
  logic [ird_pkg::VALUE_BITS-1:0] raw;
  logic [ird_pkg::VALUE_BITS-1:0] mag;
  logic                           in_acc;
  logic                           out_acc;
  logic                           start;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_low_r  <= '0;
      chars_high_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ird_pkg::REG_DIGIT_CHARS_LOW:  chars_low_r  <= cfg_data;
        ird_pkg::REG_DIGIT_CHARS_HIGH: chars_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ird_base_check u_base (
    .chars_low  (chars_low_r),
    .chars_high (chars_high_r),
    .base       (base)
  );

  // Magnitude of the input; the most negative value maps onto itself.
  always_comb begin
    raw = in_value;
    mag = raw[ird_pkg::VALUE_BITS-1] ? (~raw + ird_pkg::VALUE_BITS'(1)) : raw;
  end

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign start   = in_acc && base.valid;

  ird_serial_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operand   (mag),
    .radix     (base.radix),
    .last_slot (last_slot),
    .status    (div_status),
    .digit     (div_digit)
  );

  ird_digit_stack u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (div_status.push),
    .pop        (out_acc),
    .push_digit (div_digit),
    .top_digit  (top_digit),
    .count      (count),
    .last_slot  (last_slot)
  );

  // Control: take an item, convert it, then hand out its digits.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ird_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (start) begin
          state_nxt = ird_pkg::ST_CONV;
        end
      end
      ird_pkg::ST_CONV: begin
        if (div_status.done) begin
          state_nxt = ird_pkg::ST_OUT;
        end
      end
      ird_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready && out_last_digit) begin
          state_nxt = ird_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ird_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ird_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output character comes from the table entry for the top digit.
  assign out_digit_char = ird_pkg::table_byte(chars_low_r, chars_high_r,
                                              ird_pkg::TABLE_POS_W'(top_digit));
  assign out_last_digit = count == ird_pkg::COUNT_W'(1);

endmodule

FILE: src/ird_base_check.sv
// Digit table decoder: finds the radix (bytes before the first zero byte)
// and flags tables with sign characters or repeated characters. Uses ird_pkg.
module ird_base_check (
  input  logic [ird_pkg::CFG_DATA_W-1:0] chars_low,
  input  logic [ird_pkg::CFG_DATA_W-1:0] chars_high,
  output ird_pkg::base_info_t            base
);

  logic [ird_pkg::CHAR_W-1:0]  bytes [ird_pkg::MAX_RADIX];
  logic [ird_pkg::RADIX_W-1:0] radix;
  logic                        bad_char;
  logic                        dup_char;

  // Unpack the table positions that can fall inside a radix.
  always_comb begin
    for (int i = 0; i < ird_pkg::MAX_RADIX; i++) begin
      bytes[i] = ird_pkg::table_byte(chars_low, chars_high,
                                     ird_pkg::TABLE_POS_W'(i));
    end
  end

  // The radix is the position of the first zero byte, or the full size.
  always_comb begin
    radix = ird_pkg::RADIX_W'(ird_pkg::MAX_RADIX);
    for (int i = ird_pkg::MAX_RADIX - 1; i >= 0; i--) begin
      if (bytes[i] == '0) begin
        radix = ird_pkg::RADIX_W'(i);
      end
    end
  end

  // Sign characters and repeats only count inside the radix.
  always_comb begin
    bad_char = 1'b0;
    dup_char = 1'b0;
    for (int i = 0; i < ird_pkg::MAX_RADIX; i++) begin
      if (ird_pkg::RADIX_W'(i) < radix) begin
        if (bytes[i] == ird_pkg::CHAR_PLUS || bytes[i] == ird_pkg::CHAR_MINUS) begin
          bad_char = 1'b1;
        end
        for (int j = 0; j < i; j++) begin
          if (bytes[i] == bytes[j]) begin
            dup_char = 1'b1;
          end
        end
      end
    end
  end

  assign base.radix = radix;
  assign base.valid = (radix >= ird_pkg::RADIX_W'(2)) && !bad_char && !dup_char;

endmodule

FILE: src/ird_serial_div.sv
// Bit-serial restoring divider: shifts the magnitude through a narrow
// remainder, one quotient bit a cycle, and repeats on each quotient. Uses ird_pkg.
module ird_serial_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ird_pkg::VALUE_BITS-1:0] operand,
  input  logic [ird_pkg::RADIX_W-1:0]    radix,
  input  logic                           last_slot,
  output ird_pkg::div_status_t           status,
  output logic [ird_pkg::DIGIT_W-1:0]    digit
);

  logic                           run_r, run_nxt;
  logic [ird_pkg::BIT_W-1:0]      bit_r, bit_nxt;
  logic [ird_pkg::VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [ird_pkg::DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [ird_pkg::REM_W-1:0]      rem_shift;
  logic [ird_pkg::REM_W-1:0]      rem_sub;
  logic                           q_bit;
  logic [ird_pkg::VALUE_BITS-1:0] quot;
  logic                           digit_end;

  // One restoring step: bring in the next bit and subtract if it fits.
  always_comb begin
    rem_shift = {rem_r, mag_r[ird_pkg::VALUE_BITS-1]};
    q_bit     = rem_shift >= ird_pkg::REM_W'(radix);
    rem_sub   = q_bit ? (rem_shift - ird_pkg::REM_W'(radix)) : rem_shift;
    quot      = {mag_r[ird_pkg::VALUE_BITS-2:0], q_bit};
    digit_end = run_r && (bit_r == ird_pkg::BIT_W'(ird_pkg::VALUE_BITS - 1));
  end

  // A digit is finished after a full pass over the word; the conversion
  // ends when the quotient is zero or this digit fills the digit store.
  always_comb begin
    status.push = digit_end;
    status.done = digit_end && ((quot == '0) || last_slot);
    digit       = rem_sub[ird_pkg::DIGIT_W-1:0];
    run_nxt     = run_r;
    bit_nxt     = bit_r;
    mag_nxt     = mag_r;
    rem_nxt     = rem_r;
    if (start) begin
      run_nxt = 1'b1;
      bit_nxt = '0;
      mag_nxt = operand;
      rem_nxt = '0;
    end else if (run_r) begin
      bit_nxt = bit_r + ird_pkg::BIT_W'(1);
      mag_nxt = quot;
      rem_nxt = digit_end ? '0 : rem_sub[ird_pkg::DIGIT_W-1:0];
      if (status.done) begin
        run_nxt = 1'b0;
      end
    end
  end

  // Control registers reset; the datapath does not need to.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      bit_r <= '0;
    end else begin
      run_r <= run_nxt;
      bit_r <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
  end

endmodule

FILE: src/ird_digit_stack.sv
// Last-in first-out digit store built as a shift register: digits arrive
// least significant first and leave most significant first. Uses ird_pkg.
module ird_digit_stack (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic                          pop,
  input  logic [ird_pkg::DIGIT_W-1:0]   push_digit,
  output logic [ird_pkg::DIGIT_W-1:0]   top_digit,
  output logic [ird_pkg::COUNT_W-1:0]   count,
  output logic                          last_slot
);

  logic [ird_pkg::DIGIT_W-1:0] stk_r   [ird_pkg::MAX_DIGITS];
  logic [ird_pkg::DIGIT_W-1:0] stk_nxt [ird_pkg::MAX_DIGITS];
  logic [ird_pkg::COUNT_W-1:0] count_r, count_nxt;

  // A push moves every entry one place deeper; a pop moves them back.
  always_comb begin
    stk_nxt   = stk_r;
    count_nxt = count_r;
    if (push) begin
      stk_nxt[0] = push_digit;
      for (int k = 1; k < ird_pkg::MAX_DIGITS; k++) begin
        stk_nxt[k] = stk_r[k-1];
      end
      count_nxt = count_r + ird_pkg::COUNT_W'(1);
    end else if (pop) begin
      for (int k = 0; k < ird_pkg::MAX_DIGITS - 1; k++) begin
        stk_nxt[k] = stk_r[k+1];
      end
      count_nxt = count_r - ird_pkg::COUNT_W'(1);
    end
  end

  // Only the fill count is control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stk_r <= stk_nxt;
  end

  assign top_digit = stk_r[0];
  assign count     = count_r;
  assign last_slot = count_r == ird_pkg::COUNT_W'(ird_pkg::MAX_DIGITS - 1);

endmodule

FILE: src/ird_checker.sv
// Port-level checker for the integer to radix digits unit, with the bind
// that attaches it to the top level. Uses ird_pkg for widths.
module ird_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic signed [ird_pkg::VALUE_BITS-1:0] in_value,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [ird_pkg::CHAR_W-1:0]            out_digit_char,
  input logic                                  out_last_digit,
  input logic                                  cfg_valid,
  input logic                                  cfg_ready,
  input logic [ird_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input logic [ird_pkg::CFG_DATA_W-1:0]        cfg_data
);

  // A stalled result item holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit_char)
                                && $stable(out_last_digit))
    else $error("stalled result item changed");

  // Input is never taken while digits are being delivered.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while results pending");

  // No digit is offered right after an accept.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result item right after input item");

  // Delivering the final digit returns the unit to accepting input.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_digit |=> in_ready && !out_valid)
    else $error("unit not idle after final digit");

endmodule

bind integer_to_radix_digits_unit ird_checker u_ird_checker (.*);

FILE: sim/testbench.sv
// Testbench for integer_to_radix_digits_unit: loads digit tables, sends signed
// values, predicts each digit character and checks it against the output.
// Depends on ird_pkg and the unit's top level.
module testbench;

  // One expected output character.
  typedef struct packed {
    logic [ird_pkg::CHAR_W-1:0] digit_char;
    logic                       last_digit;
  } digit_t;

  // Ways a generated digit table can be spoiled.
  typedef enum int {
    FLAW_NONE,
    FLAW_PLUS,
    FLAW_MINUS,
    FLAW_REPEAT,
    FLAW_SHORT
  } table_flaw_t;

  // Fixed tables for the directed part.
  localparam logic [ird_pkg::CFG_DATA_W-1:0] DEC_LO   = 64'h3736_3534_3332_3130;
  localparam logic [ird_pkg::CFG_DATA_W-1:0] DEC_HI   = 64'h0000_0000_0000_3938;
  localparam logic [ird_pkg::CFG_DATA_W-1:0] BIN_LO   = 64'hFFFF_FFFF_FF00_3130;
  localparam logic [ird_pkg::CFG_DATA_W-1:0] BIN_HI   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [ird_pkg::CFG_DATA_W-1:0] EXT_LO   = 64'hF8F9_FAFB_FCFD_FEFF;
  localparam logic [ird_pkg::CFG_DATA_W-1:0] EXT_HI   = 64'h0102_0304_0506_0780;
  localparam logic [ird_pkg::CFG_DATA_W-1:0] HEX_LO   = 64'h3736_3534_3332_3130;
  localparam logic [ird_pkg::CFG_DATA_W-1:0] DASH_HI  = 64'h2D65_6463_6261_3938;
  localparam logic [ird_pkg::CFG_DATA_W-1:0] ONE_LO   = 64'h0000_0000_0000_0030;
  localparam logic [ird_pkg::CFG_DATA_W-1:0] PLUS_LO  = 64'h0000_0000_002B_3130;
  localparam logic [ird_pkg::CFG_DATA_W-1:0] MINUS_LO = 64'h0000_0000_002D_3130;
  localparam logic [ird_pkg::CFG_DATA_W-1:0] TWICE_LO = 64'h0000_0000_0031_3130;

  logic                                  clk;
  logic                                  rst_n = 1'b0;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic signed [ird_pkg::VALUE_BITS-1:0] in_value = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic [ird_pkg::CHAR_W-1:0]            out_digit_char;
  logic                                  out_last_digit;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [ird_pkg::CFG_INDEX_W-1:0]       cfg_index = '0;
  logic [ird_pkg::CFG_DATA_W-1:0]        cfg_data = '0;

  // Testbench copy of the digit table and the run's bookkeeping.
  logic [ird_pkg::CFG_DATA_W-1:0]        chars_lo = '0;
  logic [ird_pkg::CFG_DATA_W-1:0]        chars_hi = '0;
  logic                                  value_taken = 1'b0;
  int                                    send_idle_pct = 0;
  int                                    recv_idle_pct = 0;
  int                                    error_count = 0;
  logic signed [ird_pkg::VALUE_BITS-1:0] pending_values[$];
  digit_t                                expected_digits[$];

  integer_to_radix_digits_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Free-running clock, period 10.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Character at position pos of a table held as two 64-bit words.
  function automatic logic [ird_pkg::CHAR_W-1:0] symbol_at(
    input logic [ird_pkg::CFG_DATA_W-1:0] lo,
    input logic [ird_pkg::CFG_DATA_W-1:0] hi,
    input int                             pos
  );
    logic [ird_pkg::CFG_DATA_W-1:0] word;
    word = (pos < 8) ? (lo >> (8 * pos)) : (hi >> (8 * (pos - 8)));
    return word[ird_pkg::CHAR_W-1:0];
  endfunction

  // Radix of a table, or zero when the table is not a usable base.
  function automatic int base_radix(
    input logic [ird_pkg::CFG_DATA_W-1:0] lo,
    input logic [ird_pkg::CFG_DATA_W-1:0] hi
  );
    int n;
    n = 0;
    while (n < ird_pkg::MAX_RADIX && symbol_at(lo, hi, n) != 8'h00) n++;
    if (n < 2) return 0;
    for (int i = 0; i < n; i++) begin
      if (symbol_at(lo, hi, i) == ird_pkg::CHAR_PLUS ||
          symbol_at(lo, hi, i) == ird_pkg::CHAR_MINUS) return 0;
      for (int j = 0; j < i; j++) begin
        if (symbol_at(lo, hi, j) == symbol_at(lo, hi, i)) return 0;
      end
    end
    return n;
  endfunction

  // Queue the characters that one value must produce under the current table.
  function automatic void predict_digits(
    input logic signed [ird_pkg::VALUE_BITS-1:0] value
  );
    int                             radix;
    logic [ird_pkg::VALUE_BITS-1:0] mag;
    int unsigned                    digit_vals[$];
    digit_t                         d;
    radix = base_radix(chars_lo, chars_hi);
    if (radix == 0) return;
    // The most negative value wraps to 2^31, which is its exact magnitude.
    mag = value[ird_pkg::VALUE_BITS-1] ? (~value + 1'b1) : value;
    do begin
      digit_vals.push_front(mag % radix);
      mag = mag / radix;
    end while (mag != 0);
    for (int k = 0; k < digit_vals.size(); k++) begin
      d.digit_char = symbol_at(chars_lo, chars_hi, digit_vals[k]);
      d.last_digit = (k == digit_vals.size() - 1);
      expected_digits.push_back(d);
    end
  endfunction

  // Random table of the given radix with distinct legal characters,
  // optionally spoiled. Bytes past the terminating zero are junk.
  function automatic void make_table(
    input  int                             radix,
    input  table_flaw_t                    flaw,
    output logic [ird_pkg::CFG_DATA_W-1:0] lo,
    output logic [ird_pkg::CFG_DATA_W-1:0] hi
  );
    logic [ird_pkg::CHAR_W-1:0] syms[16];
    logic [ird_pkg::CHAR_W-1:0] c;
    bit                         fresh;
    int                         pos;
    for (int i = 0; i < 16; i++) syms[i] = ird_pkg::CHAR_W'($urandom_range(255));
    for (int i = 0; i < radix; i++) begin
      do begin
        c = ird_pkg::CHAR_W'($urandom_range(1, 255));
        fresh = (c != ird_pkg::CHAR_PLUS) && (c != ird_pkg::CHAR_MINUS);
        for (int j = 0; j < i; j++) begin
          if (syms[j] == c) fresh = 1'b0;
        end
      end while (!fresh);
      syms[i] = c;
    end
    if (radix < 16) syms[radix] = 8'h00;
    case (flaw)
      FLAW_PLUS:  syms[$urandom_range(radix - 1)] = ird_pkg::CHAR_PLUS;
      FLAW_MINUS: syms[$urandom_range(radix - 1)] = ird_pkg::CHAR_MINUS;
      FLAW_REPEAT: begin
        pos = $urandom_range(1, radix - 1);
        syms[pos] = syms[$urandom_range(pos - 1)];
      end
      FLAW_SHORT: syms[$urandom_range(1)] = 8'h00;
      default: ;
    endcase
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = syms[i];
      hi[8*i +: 8] = syms[i + 8];
    end
  endfunction

  // Random value aimed at digit-count boundaries and the extremes.
  function automatic logic signed [ird_pkg::VALUE_BITS-1:0] pick_value(input int radix);
    logic [63:0]                           p;
    logic signed [ird_pkg::VALUE_BITS-1:0] v;
    case ($urandom_range(5))
      0: v = $urandom_range(3 * radix);
      1: begin
        p = 64'd1;
        repeat ($urandom_range(1, 31)) begin
          if (p * 64'(radix) <= 64'h8000_0000) p = p * 64'(radix);
        end
        v = ird_pkg::VALUE_BITS'(p - 64'($urandom_range(1)));
      end
      2: begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom;
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  // Write one register and wait for the handshake.
  task automatic write_reg(
    input logic [ird_pkg::CFG_INDEX_W-1:0] idx,
    input logic [ird_pkg::CFG_DATA_W-1:0]  data
  );
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Load both halves of a table, in random order.
  task automatic load_table(
    input logic [ird_pkg::CFG_DATA_W-1:0] lo,
    input logic [ird_pkg::CFG_DATA_W-1:0] hi
  );
    if ($urandom_range(1)) begin
      write_reg(ird_pkg::REG_DIGIT_CHARS_LOW, lo);
      write_reg(ird_pkg::REG_DIGIT_CHARS_HIGH, hi);
    end else begin
      write_reg(ird_pkg::REG_DIGIT_CHARS_HIGH, hi);
      write_reg(ird_pkg::REG_DIGIT_CHARS_LOW, lo);
    end
  endtask

  // Wait until every value is taken and every digit has come out.
  task automatic drain;
    while (pending_values.size() != 0 || in_valid) @(posedge clk);
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  // Input driver: presents the next value, idling at random between items; also sets out_ready at random.
  always @(negedge clk) begin
    if (!in_valid || value_taken) begin
      if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_value <= pending_values.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: tracks table writes, predicts on each accepted value and
  // checks each delivered character against the oldest expectation.
  always @(posedge clk) begin : monitor
    digit_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ird_pkg::REG_DIGIT_CHARS_LOW) begin
          chars_lo <= cfg_data;
        end else begin
          chars_hi <= cfg_data;
        end
      end
      if (in_valid && in_ready) predict_digits(in_value);
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          $display("%0t: unexpected digit, expected none, got char %h last %b",
                   $time, out_digit_char, out_last_digit);
          error_count++;
        end else begin
          want = expected_digits.pop_front();
          if (out_digit_char !== want.digit_char) begin
            $display("%0t: digit_char mismatch, expected %h, got %h",
                     $time, want.digit_char, out_digit_char);
            error_count++;
          end
          if (out_last_digit !== want.last_digit) begin
            $display("%0t: last_digit mismatch, expected %b, got %b",
                     $time, want.last_digit, out_last_digit);
            error_count++;
          end
        end
      end
    end
    value_taken <= rst_n && in_valid && in_ready;
  end

  // Stimulus: directed tables and values, then three rounds of random tables.
  initial begin : stimulus
    logic [ird_pkg::CFG_DATA_W-1:0] lo;
    logic [ird_pkg::CFG_DATA_W-1:0] hi;
    int                             radix;
    int                             bad_slot;
    send_idle_pct = 32;
    recv_idle_pct = 49;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty table after reset: values are dropped.
    pending_values.push_back(5);
    pending_values.push_back(-5);
    drain();

    // Decimal: zero, single and multi digit, both extremes.
    load_table(DEC_LO, DEC_HI);
    pending_values.push_back(0);
    pending_values.push_back(1);
    pending_values.push_back(-1);
    pending_values.push_back(9);
    pending_values.push_back(10);
    pending_values.push_back(-10);
    pending_values.push_back(-99);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    drain();

    // Binary with junk past the terminator: the most negative value
    // gives 32 digits.
    load_table(BIN_LO, BIN_HI);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(0);
    pending_values.push_back(-1);
    drain();

    // Full sixteen-character table with no terminator.
    load_table(EXT_LO, EXT_HI);
    pending_values.push_back(-1);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(15);
    pending_values.push_back(16);
    drain();

    // Invalid bases: one character, plus, minus, a repeat, and a minus
    // in the last table position.
    load_table(ONE_LO, DEC_HI);
    pending_values.push_back(123);
    drain();
    load_table(PLUS_LO, DEC_HI);
    pending_values.push_back(123);
    drain();
    load_table(MINUS_LO, DEC_HI);
    pending_values.push_back(123);
    drain();
    load_table(TWICE_LO, DEC_HI);
    pending_values.push_back(123);
    drain();
    load_table(HEX_LO, DASH_HI);
    pending_values.push_back(123);
    drain();

    // Random tables; each round has one spoiled table among valid ones.
    for (int round = 0; round < 3; round++) begin
      send_idle_pct = (round == 0) ? 32 : (round == 1) ? 49 : 0;
      recv_idle_pct = (round == 0) ? 49 : (round == 1) ? 32 : 0;
      bad_slot = $urandom_range(5);
      for (int t = 0; t < 6; t++) begin
        radix = $urandom_range(2, ird_pkg::MAX_RADIX);
        if (t == bad_slot) begin
          make_table(radix, table_flaw_t'($urandom_range(FLAW_PLUS, FLAW_SHORT)), lo, hi);
          load_table(lo, hi);
          repeat (4) pending_values.push_back($urandom);
        end else begin
          make_table(radix, FLAW_NONE, lo, hi);
          load_table(lo, hi);
          repeat (22) pending_values.push_back(pick_value(radix));
        end
        drain();
      end
    end

    if (error_count == 0 && expected_digits.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
